>>> sv/bsr_pkg.sv
// ============================================================================
// bsr_pkg: shared types and constants of the bisync frame receiver
// Receive phase codes, EBCDIC control characters, register indexes and the
// state and result records passed between the decoder and the top level.
// ============================================================================
`default_nettype none

package bsr_pkg;

    // Receive phases. Code 7 is unused and behaves as out of sync.
    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_IDLE   = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_TRANSP = 3'd3;
    localparam logic [2:0] PH_BCC1   = 3'd4;
    localparam logic [2:0] PH_BCC2   = 3'd5;
    localparam logic [2:0] PH_PAD    = 3'd6;

    // Fixed EBCDIC control characters.
    localparam logic [7:0] C_SOH  = 8'h01;
    localparam logic [7:0] C_STX  = 8'h02;
    localparam logic [7:0] C_ETX  = 8'h03;
    localparam logic [7:0] C_ITB  = 8'h1F;
    localparam logic [7:0] C_ETB  = 8'h26;
    localparam logic [7:0] C_ENQ  = 8'h2D;
    localparam logic [7:0] C_EOT  = 8'h37;
    localparam logic [7:0] C_NAK  = 8'h3D;
    localparam logic [7:0] C_ACK0 = 8'h70;
    localparam logic [7:0] C_ACK1 = 8'h61;

    // Configuration register indexes and reset values.
    localparam int         CFG_IDX_W       = 2;
    localparam logic [1:0] CFG_SYNC_CODE   = 2'd0;
    localparam logic [1:0] CFG_ESCAPE_CODE = 2'd1;
    localparam logic [7:0] SYNC_RESET      = 8'h32;
    localparam logic [7:0] ESCAPE_RESET    = 8'h10;

    // Bit counting: a byte is complete every eighth bit; the count saturates.
    localparam logic [3:0] BYTE_BITS = 4'd8;
    localparam logic [3:0] COUNT_MAX = 4'd15;

    typedef struct packed {
        logic [7:0] shift_byte;
        logic [3:0] bit_count;
        logic [2:0] phase;
        logic       escape_pending;
        logic       frame_empty;
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       last;
    } t_result;

    // Up to two results caused by one input item.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_emit;

endpackage

`default_nettype wire

>>> sv/bsr_in_if.sv
// ============================================================================
// bsr_in_if: input channel of the bisync frame receiver
// Carries one sampled line bit or a restart request per transfer.
// ============================================================================
`default_nettype none

interface bsr_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic line_bit;

    modport source (output valid, output kind, output line_bit, input ready);
    modport sink   (input valid, input kind, input line_bit, output ready);
endinterface

`default_nettype wire

>>> sv/bsr_out_if.sv
// ============================================================================
// bsr_out_if: result channel of the bisync frame receiver
// Carries one received frame byte per transfer with its end marks.
// ============================================================================
`default_nettype none

interface bsr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;
    logic       last;

    modport source (output valid, output data_byte, output frame_end, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_end, input last,
                    output ready);
endinterface

`default_nettype wire

>>> sv/bsr_cfg_if.sv
// ============================================================================
// bsr_cfg_if: configuration write channel of the bisync frame receiver
// Carries a register index and the data to write into it.
// ============================================================================
`default_nettype none

interface bsr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bsr_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/bsr_decode.sv
// ============================================================================
// bsr_decode: receive state update for one input item
// Shifts in the line bit, hunts for sync, and on each complete byte walks
// the bisync receive phases, producing up to two frame bytes.
// ============================================================================
`default_nettype none

module bsr_decode (
    input  bsr_pkg::t_state i_state,
    input  logic            i_kind,
    input  logic            i_line_bit,
    input  logic [7:0]      i_sync_code,
    input  logic [7:0]      i_escape_code,
    output bsr_pkg::t_state o_state,
    output bsr_pkg::t_emit  o_emit
);

    bsr_pkg::t_state nx;
    logic [1:0]      cnt;
    logic [7:0]      d0;
    logic [7:0]      d1;
    logic            e0;
    logic            e1;
    logic [7:0]      b;

    assign b = {i_line_bit, i_state.shift_byte[7:1]};

    // Next state and emitted bytes.
    always_comb begin
        nx  = i_state;
        cnt = 2'd0;
        d0  = '0;
        d1  = '0;
        e0  = 1'b0;
        e1  = 1'b0;
        if (i_kind) begin
            nx.phase = bsr_pkg::PH_HUNT;
        end else begin
            nx.shift_byte = b;
            if (i_state.bit_count != bsr_pkg::COUNT_MAX) begin
                nx.bit_count = i_state.bit_count + 4'd1;
            end
            if (i_state.phase == bsr_pkg::PH_HUNT || i_state.phase > bsr_pkg::PH_PAD) begin
                // Bit-by-bit hunt for the sync pattern.
                nx.phase = bsr_pkg::PH_HUNT;
                if (b == i_sync_code) begin
                    nx.phase          = bsr_pkg::PH_IDLE;
                    nx.escape_pending = 1'b0;
                    nx.bit_count      = '0;
                    cnt               = 2'd1;
                    d0                = b;
                end
            end else if (nx.bit_count == bsr_pkg::BYTE_BITS) begin
                nx.bit_count = '0;
                case (i_state.phase)
                    bsr_pkg::PH_PAD: begin
                        cnt               = 2'd1;
                        d0                = b;
                        e0                = 1'b1;
                        nx.phase          = bsr_pkg::PH_IDLE;
                        nx.escape_pending = 1'b0;
                    end
                    bsr_pkg::PH_IDLE, bsr_pkg::PH_DATA: begin
                        if (b == i_sync_code) begin
                            // A SYN is stored only at the start of a frame.
                            if (i_state.frame_empty) begin
                                cnt = 2'd1;
                                d0  = b;
                            end
                        end else if (b == i_escape_code) begin
                            nx.escape_pending = 1'b1;
                        end else if (i_state.escape_pending && b == bsr_pkg::C_STX) begin
                            nx.phase          = bsr_pkg::PH_TRANSP;
                            cnt               = 2'd2;
                            d0                = i_escape_code;
                            d1                = bsr_pkg::C_STX;
                            nx.escape_pending = 1'b0;
                        end else if (b == bsr_pkg::C_STX || b == bsr_pkg::C_SOH) begin
                            nx.phase          = bsr_pkg::PH_DATA;
                            cnt               = 2'd1;
                            d0                = b;
                            nx.escape_pending = 1'b0;
                        end else if (i_state.phase == bsr_pkg::PH_IDLE) begin
                            if (i_state.escape_pending &&
                                (b == bsr_pkg::C_ACK0 || b == bsr_pkg::C_ACK1)) begin
                                cnt      = 2'd2;
                                d0       = i_escape_code;
                                d1       = b;
                                nx.phase = bsr_pkg::PH_PAD;
                            end else begin
                                nx.escape_pending = 1'b0;
                                if (b == bsr_pkg::C_EOT || b == bsr_pkg::C_NAK) begin
                                    cnt      = 2'd1;
                                    d0       = b;
                                    nx.phase = bsr_pkg::PH_PAD;
                                end
                            end
                        end else begin
                            // Normal data text byte.
                            cnt = 2'd1;
                            d0  = b;
                            if (b == bsr_pkg::C_ETB || b == bsr_pkg::C_ETX) begin
                                nx.phase = bsr_pkg::PH_BCC1;
                            end
                        end
                    end
                    bsr_pkg::PH_TRANSP: begin
                        if (i_state.escape_pending && b == i_escape_code) begin
                            // DLE DLE unstuffs to a single DLE.
                            cnt               = 2'd1;
                            d0                = i_escape_code;
                            nx.escape_pending = 1'b0;
                        end else if (i_state.escape_pending && b == bsr_pkg::C_ENQ) begin
                            cnt               = 2'd2;
                            d0                = i_escape_code;
                            d1                = b;
                            e1                = 1'b1;
                            nx.escape_pending = 1'b0;
                            nx.phase          = bsr_pkg::PH_IDLE;
                        end else if (i_state.escape_pending &&
                                     (b == bsr_pkg::C_ITB || b == bsr_pkg::C_ETX ||
                                      b == bsr_pkg::C_ETB)) begin
                            cnt      = 2'd2;
                            d0       = i_escape_code;
                            d1       = b;
                            nx.phase = bsr_pkg::PH_BCC1;
                        end else if (b == i_escape_code) begin
                            nx.escape_pending = 1'b1;
                        end else begin
                            cnt = 2'd1;
                            d0  = b;
                        end
                    end
                    bsr_pkg::PH_BCC1: begin
                        cnt      = 2'd1;
                        d0       = b;
                        nx.phase = bsr_pkg::PH_BCC2;
                    end
                    bsr_pkg::PH_BCC2: begin
                        cnt      = 2'd1;
                        d0       = b;
                        nx.phase = bsr_pkg::PH_PAD;
                    end
                    default: begin
                        nx.phase = i_state.phase;
                    end
                endcase
            end
        end
        // The frame is empty again exactly when the last stored byte ended it.
        if (cnt == 2'd1) begin
            nx.frame_empty = e0;
        end else if (cnt == 2'd2) begin
            nx.frame_empty = e1;
        end
    end

    assign o_state              = nx;
    assign o_emit.count         = cnt;
    assign o_emit.res0.data_byte = d0;
    assign o_emit.res0.frame_end = e0;
    assign o_emit.res0.last      = (cnt == 2'd1);
    assign o_emit.res1.data_byte = d1;
    assign o_emit.res1.frame_end = e1;
    assign o_emit.res1.last      = 1'b1;

endmodule

`default_nettype wire

>>> sv/bisync_frame_receiver.sv
// The results of an accepted item are written to the result queue, which offers them on o_out.
// Throughput: one item per cycle while i_in.ready is high; each item is decoded in the cycle it is accepted.
// i_in.ready drops only while the result queue lacks room for two more results,
// which sets the rate when the result side stalls.
// Reset (synchronous, active low) clears the receive state to out of sync,
// empties the result queue and restores the sync and escape codes.
// ============================================================================
// bisync_frame_receiver: bisync line receiver
// Assembles line bits into bytes after sync and emits the bytes of each
// received frame, marking frame ends.
// ============================================================================
`default_nettype none

module bisync_frame_receiver #(
    parameter int RES_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bsr_in_if.sink           i_in,
    bsr_out_if.source        o_out,
    bsr_cfg_if.sink          i_cfg
);

    localparam int PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
    localparam int CNT_W = $clog2(RES_DEPTH + 1);

    bsr_pkg::t_state  r_state;
    bsr_pkg::t_state  n_state;
    bsr_pkg::t_emit   dec_emit;
    logic [7:0]       r_sync_code;
    logic [7:0]       r_escape_code;
    bsr_pkg::t_result r_buf [RES_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr_next;
    logic             in_take;
    logic             out_take;
    logic [1:0]       push_n;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RES_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign in_take  = i_in.valid && i_in.ready;
    assign out_take = o_out.valid && o_out.ready;
    assign push_n   = in_take ? dec_emit.count : 2'd0;
    assign wr_next  = ptr_inc(r_wr_ptr);

    // Room for the worst case of two results per item.
    assign i_in.ready  = (r_count <= CNT_W'(RES_DEPTH - 2));
    assign i_cfg.ready = 1'b1;

    bsr_decode u_decode (
        .i_state       (r_state),
        .i_kind        (i_in.kind),
        .i_line_bit    (i_in.line_bit),
        .i_sync_code   (r_sync_code),
        .i_escape_code (r_escape_code),
        .o_state       (n_state),
        .o_emit        (dec_emit)
    );

    // Receive state advances on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.shift_byte     <= '0;
            r_state.bit_count      <= '0;
            r_state.phase          <= bsr_pkg::PH_HUNT;
            r_state.escape_pending <= 1'b0;
            r_state.frame_empty    <= 1'b1;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_code   <= bsr_pkg::SYNC_RESET;
            r_escape_code <= bsr_pkg::ESCAPE_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                bsr_pkg::CFG_SYNC_CODE:   r_sync_code   <= i_cfg.data;
                bsr_pkg::CFG_ESCAPE_CODE: r_escape_code <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_buf[r_wr_ptr] <= dec_emit.res0;
        end
        if (push_n == 2'd2) begin
            r_buf[wr_next] <= dec_emit.res1;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_n == 2'd1) begin
                r_wr_ptr <= wr_next;
            end else if (push_n == 2'd2) begin
                r_wr_ptr <= ptr_inc(wr_next);
            end
            if (out_take) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + CNT_W'(push_n) - CNT_W'(out_take);
        end
    end

    assign o_out.valid     = (r_count != '0);
    assign o_out.data_byte = r_buf[r_rd_ptr].data_byte;
    assign o_out.frame_end = r_buf[r_rd_ptr].frame_end;
    assign o_out.last      = r_buf[r_rd_ptr].last;

endmodule

`default_nettype wire

>>> sv/bsr_checker.sv
// ============================================================================
// bsr_checker: port-level checks of the bisync frame receiver
// Watches the channels of the top level and is attached to it by bind.
// ============================================================================
`default_nettype none

module bsr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_kind,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_data_byte,
    input wire logic       i_out_frame_end,
    input wire logic       i_out_last
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data_byte) &&
                                           $stable(i_out_frame_end) && $stable(i_out_last)))
        else $error("stalled result changed");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // A frame end is always the final result of its input item.
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_frame_end) |-> i_out_last)
        else $error("frame end not marked last");

    // Back pressure on the input only arises from queued results.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no pending result");

    // A restart produces no result.
    a_restart_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_kind && !i_out_valid) |=> !i_out_valid)
        else $error("restart produced a result");

endmodule

bind bisync_frame_receiver bsr_checker u_bsr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_kind       (i_in.kind),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_data_byte (o_out.data_byte),
    .i_out_frame_end (o_out.frame_end),
    .i_out_last      (o_out.last)
);

`default_nettype wire
